// ===== design/assert_macros.svh =====
// assertion macros shared by the design modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/dcq_pkg.sv =====
// types, constants and helpers for the dual circular queue
package dcq_pkg;

  // sizing
  localparam int HALF_DEPTH = 4;
  localparam int WORD_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = $clog2(HALF_DEPTH);
  localparam int ADDR_W     = $clog2(2 * HALF_DEPTH);
  localparam int DEPTH      = 2 * HALF_DEPTH;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  // word returned by a refused dequeue
  localparam logic signed [VALUE_W-1:0] EMPTY_READ = -32'sd999;

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_RESP
  } ctl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // next index within one half, wrapping to the base
  function automatic idx_t wrap_next(input idx_t idx);
    idx_t n;
    n = (idx == IDX_W'(HALF_DEPTH - 1)) ? '0 : idx + 1'b1;
    return n;
  endfunction

  // absolute slot of an index in the selected half
  function automatic addr_t slot_addr(input logic sel, input idx_t idx);
    addr_t a;
    a = ADDR_W'(idx) + (sel ? ADDR_W'(HALF_DEPTH) : '0);
    return a;
  endfunction

endpackage

// ===== design/dcq_ctrl.sv =====
// sequencing state machine for the dual circular queue
`include "assert_macros.svh"

module dcq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dcq_pkg::dp_stat_t stat_i,
  output dcq_pkg::ctl_cmd_t cmd_o
);
  import dcq_pkg::*;

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.load_item = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = CS_RESP;
      end
      CS_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_to_exec, in_valid_i && in_ready_o, state_q == CS_EXEC)
  `ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0({cmd_o.load_item, cmd_o.exec, cmd_o.load_out}))
  `ASSERT_IMPL(a_load_when_free, cmd_o.load_out, stat_i.out_free)

endmodule

// ===== design/dcq_dpath.sv =====
// pointers, shared slot array and output register of the dual circular queue
`include "assert_macros.svh"

module dcq_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dcq_pkg::ctl_cmd_t                   cmd_i,
  output dcq_pkg::dp_stat_t                   stat_o,
  input  logic                                in_action_i,
  input  logic                                in_queue_sel_i,
  input  logic signed [dcq_pkg::VALUE_W-1:0]  in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dcq_pkg::VALUE_W-1:0]  out_read_value_o,
  output logic [dcq_pkg::STATUS_W-1:0]        out_status_o
);
  import dcq_pkg::*;

  // latched item
  logic                       action_q;
  logic                       sel_q;
  logic signed [VALUE_W-1:0]  value_q;

  // per-queue pointers
  idx_t head_q  [2];
  idx_t head_d  [2];
  idx_t tail_q  [2];
  idx_t tail_d  [2];
  logic empty_q [2];
  logic empty_d [2];

  // shared slot array
  word_t mem_q [DEPTH];
  logic  mem_we;
  logic  mem_re;
  addr_t wr_addr;
  addr_t rd_addr;
  word_t wr_word;
  word_t rd_q;

  // response stage
  status_e status_q, status_d;
  logic    use_mem_q, use_mem_d;

  // output register
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  status_e                   out_status_q;
  logic signed [VALUE_W-1:0] rsp_value;

  // selected queue view
  idx_t sel_head;
  idx_t sel_tail;
  logic sel_empty;
  idx_t tail_next;
  idx_t head_next;

  assign sel_head  = head_q[sel_q];
  assign sel_tail  = tail_q[sel_q];
  assign sel_empty = empty_q[sel_q];
  assign tail_next = wrap_next(sel_tail);
  assign head_next = wrap_next(sel_head);
  assign wr_word   = WORD_WIDTH'(value_q);

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= in_action_i;
      sel_q    <= in_queue_sel_i;
      value_q  <= in_value_i;
    end
  end

  // enqueue and dequeue decision
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    wr_addr   = slot_addr(sel_q, '0);
    rd_addr   = slot_addr(sel_q, sel_head);
    status_d  = ST_OK;
    use_mem_d = 1'b0;
    if (cmd_i.exec) begin
      if (action_q == ACT_ENQ) begin
        if (sel_empty) begin
          head_d[sel_q]  = '0;
          tail_d[sel_q]  = '0;
          empty_d[sel_q] = 1'b0;
          mem_we         = 1'b1;
        end else if (tail_next == sel_head) begin
          status_d = ST_FULL;
        end else begin
          tail_d[sel_q] = tail_next;
          wr_addr       = slot_addr(sel_q, tail_next);
          mem_we        = 1'b1;
        end
      end else begin
        if (sel_empty) begin
          status_d = ST_EMPTY;
        end else begin
          mem_re    = 1'b1;
          use_mem_d = 1'b1;
          if (sel_head == sel_tail) begin
            head_d[sel_q]  = '0;
            tail_d[sel_q]  = '0;
            empty_d[sel_q] = 1'b1;
          end else begin
            head_d[sel_q] = head_next;
          end
        end
      end
    end
  end

  // pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q[0]  <= '0;
      head_q[1]  <= '0;
      tail_q[0]  <= '0;
      tail_q[1]  <= '0;
      empty_q[0] <= 1'b1;
      empty_q[1] <= 1'b1;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // slot array, at most one access per item
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (mem_re) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // response kind
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      use_mem_q <= use_mem_d;
    end
  end

  // response word
  always_comb begin
    if (use_mem_q) begin
      rsp_value = VALUE_W'(signed'(rd_q));
    end else if (status_q == ST_EMPTY) begin
      rsp_value = EMPTY_READ;
    end else begin
      rsp_value = '0;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q  <= rsp_value;
      out_status_q <= status_q;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_read_value_o = out_value_q;
  assign out_status_o     = out_status_q;

  `ASSERT_NEXT(a_deq_empty_status, cmd_i.exec && action_q == ACT_DEQ && sel_empty,
               status_q == ST_EMPTY)
  `ASSERT_NEXT(a_enq_fills, cmd_i.exec && action_q == ACT_ENQ, !empty_q[sel_q])
  `ASSERT_IMPL(a_empty0_at_base, empty_q[0], head_q[0] == '0 && tail_q[0] == '0)
  `ASSERT_IMPL(a_empty1_at_base, empty_q[1], head_q[1] == '0 && tail_q[1] == '0)

endmodule

// ===== design/dual_circular_queue_shared_array_core.sv =====
// top level of the dual circular queue sharing one slot array
//
//   channel   direction  tdata                 tuser
//   s_axis    in         [31:0] value          [0] action, [1] queue_sel
//   m_axis    out        [31:0] read_value     [1:0] status
//
// an item passes the transfer, then the pointer update and the single slot-array
// access, then the load of the output register
// the output register decouples the sides: a new item is taken while a result waits
// a result that cannot enter the occupied output register holds the item in response
// reset clears both queues to empty; the slot array is not cleared
module dual_circular_queue_shared_array_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dcq_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] value
  input  logic [1:0]                         s_axis_tuser,  // [0] action, [1] queue_sel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dcq_pkg::VALUE_W-1:0]        m_axis_tdata,  // [31:0] read_value
  output logic [dcq_pkg::STATUS_W-1:0]       m_axis_tuser   // [1:0] status
);
  import dcq_pkg::*;

  ctl_cmd_t                  cmd;
  dp_stat_t                  stat;
  logic signed [VALUE_W-1:0] read_value;

  // sequencing
  dcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // queue state and storage
  dcq_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_action_i      (s_axis_tuser[0]),
    .in_queue_sel_i   (s_axis_tuser[1]),
    .in_value_i       (signed'(s_axis_tdata)),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_read_value_o (read_value),
    .out_status_o     (m_axis_tuser)
  );

  assign m_axis_tdata = unsigned'(read_value);

endmodule
